### src/jacobi_polynomial_eval_assert.svh
// assertion macros for the jacobi evaluator controller
`ifndef JACOBI_POLYNOMIAL_EVAL_ASSERT_SVH
`define JACOBI_POLYNOMIAL_EVAL_ASSERT_SVH

// same-cycle implication, checked outside reset
`define JPE_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("jacobi evaluator check failed");

// next-cycle implication, checked outside reset
`define JPE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("jacobi evaluator check failed");

`endif

### src/jpe_pkg.sv
package jpe_pkg;

    localparam int MAX_DEGREE = 63;
    localparam int IN_DEG_W   = 6;
    localparam int DEG_W      = $clog2(MAX_DEGREE + 1);
    localparam int CFG_W      = 17;
    localparam int EXP_W      = CFG_W + 1;
    localparam int POINT_W    = 32;
    localparam int VAL_W      = 64;
    localparam int WIDE_W     = 2 * VAL_W;

    // shared multiplier: radix-16 shift and add
    localparam int MUL_DIGIT_W = 4;
    localparam int MUL_STEPS   = VAL_W / MUL_DIGIT_W;
    localparam int MUL_CNT_W   = $clog2(MUL_STEPS);

    // divider: one quotient bit per cycle
    localparam int DIV_STEPS = WIDE_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    localparam logic signed [VAL_W-1:0] SAT_MAX = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic signed [VAL_W-1:0] SAT_MIN = {1'b1, {(VAL_W-1){1'b0}}};
    localparam logic signed [VAL_W-1:0] ONE_Q31 = 64'sh0000_0000_8000_0000;
    localparam logic signed [VAL_W-1:0] Q10_ONE = 64'sd1024;
    localparam logic signed [VAL_W-1:0] Q10_TWO = 64'sd2048;
    localparam logic signed [EXP_W-1:0] EXP_SHIFT = 18'sd1024;

    localparam logic [0:0] REG_ALPHA = 1'b0;
    localparam logic [0:0] REG_BETA  = 1'b1;

    typedef enum logic [3:0] {
        OP_INIT,
        OP_M1,
        OP_M2,
        OP_M3,
        OP_M4,
        OP_M5,
        OP_M6,
        OP_M7,
        OP_M8,
        OP_M9,
        OP_M10,
        OP_M11,
        OP_M12,
        OP_FINAL
    } op_t;

    typedef struct packed {
        logic load;
        logic set_zero;
        logic set_one;
        logic mul_start;
        logic div_start;
        logic out_load;
        op_t  op;
    } ctrl_cmd_t;

    typedef struct packed {
        logic deriv;
        logic deg_zero;
        logic jd_zero;
        logic n_done;
        logic mul_done;
        logic div_done;
    } dp_stat_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] value;
        logic                    ovf;
    } sat_t;

    // arithmetic right shift with round half up, then clamp to 64 bits
    function automatic sat_t rsh_sat(input logic signed [WIDE_W-1:0] a,
                                     input int unsigned k);
        logic signed [WIDE_W-1:0] r;
        sat_t s;
        r = a + (128'sd1 <<< (k - 1));
        r = r >>> k;
        s.ovf = !((r[WIDE_W-1:VAL_W-1] == '0) || (r[WIDE_W-1:VAL_W-1] == '1));
        if (s.ovf)
        begin
            s.value = r[WIDE_W-1] ? SAT_MIN : SAT_MAX;
        end
        else
        begin
            s.value = r[VAL_W-1:0];
        end
        return s;
    endfunction

endpackage

### src/jpe_if.sv
interface jpe_req_if;
    logic                                   valid;
    logic                                   ready;
    logic                                   cmd;
    logic [jpe_pkg::IN_DEG_W-1:0]           degree;
    logic signed [jpe_pkg::POINT_W-1:0]     point;

    modport source (output valid, cmd, degree, point, input ready);
    modport sink   (input valid, cmd, degree, point, output ready);
endinterface

interface jpe_rsp_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [jpe_pkg::VAL_W-1:0]       value;
    logic                                   overflow;

    modport source (output valid, value, overflow, input ready);
    modport sink   (input valid, value, overflow, output ready);
endinterface

interface jpe_cfg_if;
    logic                                   valid;
    logic                                   ready;
    logic [0:0]                             index;
    logic signed [jpe_pkg::CFG_W-1:0]       data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### src/jpe_mul.sv
module jpe_mul (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic signed [jpe_pkg::VAL_W-1:0]    op_a,
    input  logic signed [jpe_pkg::VAL_W-1:0]    op_b,
    output logic                                done,
    output logic signed [jpe_pkg::WIDE_W-1:0]   product
);

    logic [jpe_pkg::WIDE_W-1:0]    mcand_reg;
    logic [jpe_pkg::VAL_W-1:0]     mplier_reg;
    logic [jpe_pkg::WIDE_W-1:0]    acc_reg;
    logic                          neg_reg;
    logic [jpe_pkg::MUL_CNT_W-1:0] cnt_reg;
    logic                          busy_reg;
    logic                          done_reg;
    logic [jpe_pkg::VAL_W-1:0]     mag_a;
    logic [jpe_pkg::VAL_W-1:0]     mag_b;
    logic [jpe_pkg::WIDE_W-1:0]    partial;

    assign mag_a   = op_a[jpe_pkg::VAL_W-1] ? (~op_a + 1'b1) : op_a;
    assign mag_b   = op_b[jpe_pkg::VAL_W-1] ? (~op_b + 1'b1) : op_b;
    assign partial = mcand_reg * jpe_pkg::WIDE_W'(mplier_reg[jpe_pkg::MUL_DIGIT_W-1:0]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == jpe_pkg::MUL_CNT_W'(jpe_pkg::MUL_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            mcand_reg  <= jpe_pkg::WIDE_W'(mag_a);
            mplier_reg <= mag_b;
            acc_reg    <= '0;
            neg_reg    <= op_a[jpe_pkg::VAL_W-1] ^ op_b[jpe_pkg::VAL_W-1];
        end
        else if (busy_reg)
        begin
            acc_reg    <= acc_reg + partial;
            mcand_reg  <= mcand_reg << jpe_pkg::MUL_DIGIT_W;
            mplier_reg <= mplier_reg >> jpe_pkg::MUL_DIGIT_W;
        end
    end

    assign done    = done_reg;
    assign product = neg_reg ? $signed(~acc_reg + 1'b1) : $signed(acc_reg);

endmodule

### src/jpe_div.sv
module jpe_div (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic signed [jpe_pkg::WIDE_W-1:0]   num,
    input  logic signed [jpe_pkg::VAL_W-1:0]    den,
    output logic                                done,
    output logic signed [jpe_pkg::VAL_W-1:0]    quo,
    output logic                                ovf
);

    logic [jpe_pkg::WIDE_W-1:0]    n_reg;
    logic [jpe_pkg::WIDE_W-1:0]    q_reg;
    logic [jpe_pkg::VAL_W-1:0]     rem_reg;
    logic [jpe_pkg::VAL_W-1:0]     d_reg;
    logic                          neg_reg;
    logic                          nneg_reg;
    logic                          zero_reg;
    logic                          dz_reg;
    logic [jpe_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic                          busy_reg;
    logic                          fin_reg;
    logic                          done_reg;
    logic [jpe_pkg::VAL_W:0]       rem_wide;
    logic                          fits;
    logic [jpe_pkg::WIDE_W-1:0]    num_mag;
    logic [jpe_pkg::VAL_W-1:0]     den_mag;
    logic [jpe_pkg::VAL_W-1:0]     lim;

    assign num_mag  = num[jpe_pkg::WIDE_W-1] ? (~num + 1'b1) : num;
    assign den_mag  = den[jpe_pkg::VAL_W-1] ? (~den + 1'b1) : den;
    assign rem_wide = {rem_reg, n_reg[jpe_pkg::WIDE_W-1]};
    assign fits     = rem_wide >= {1'b0, d_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            fin_reg  <= 1'b0;
            if (start)
            begin
                cnt_reg <= '0;
                if ((num == '0) || (den == '0))
                begin
                    done_reg <= 1'b1;
                end
                else
                begin
                    busy_reg <= 1'b1;
                end
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == jpe_pkg::DIV_CNT_W'(jpe_pkg::DIV_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    fin_reg  <= 1'b1;
                end
            end
            else if (fin_reg)
            begin
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            n_reg    <= num_mag;
            d_reg    <= den_mag;
            q_reg    <= '0;
            rem_reg  <= '0;
            nneg_reg <= num[jpe_pkg::WIDE_W-1];
            neg_reg  <= num[jpe_pkg::WIDE_W-1] ^ den[jpe_pkg::VAL_W-1];
            zero_reg <= (num == '0);
            dz_reg   <= (den == '0);
        end
        else if (busy_reg)
        begin
            n_reg <= n_reg << 1;
            if (fits)
            begin
                rem_reg <= jpe_pkg::VAL_W'(rem_wide - {1'b0, d_reg});
                q_reg   <= {q_reg[jpe_pkg::WIDE_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_wide[jpe_pkg::VAL_W-1:0];
                q_reg   <= {q_reg[jpe_pkg::WIDE_W-2:0], 1'b0};
            end
        end
        else if (fin_reg)
        begin
            // round to nearest, ties away from zero
            if (rem_reg >= (d_reg - rem_reg))
            begin
                q_reg <= q_reg + 1'b1;
            end
        end
    end

    assign lim = jpe_pkg::SAT_MAX + jpe_pkg::VAL_W'(neg_reg);

    always_comb
    begin
        if (zero_reg)
        begin
            quo = '0;
            ovf = 1'b0;
        end
        else if (dz_reg)
        begin
            quo = nneg_reg ? jpe_pkg::SAT_MIN : jpe_pkg::SAT_MAX;
            ovf = 1'b1;
        end
        else if ((q_reg[jpe_pkg::WIDE_W-1:jpe_pkg::VAL_W] != '0)
                 || (q_reg[jpe_pkg::VAL_W-1:0] > lim))
        begin
            quo = neg_reg ? jpe_pkg::SAT_MIN : jpe_pkg::SAT_MAX;
            ovf = 1'b1;
        end
        else
        begin
            quo = neg_reg ? $signed(~q_reg[jpe_pkg::VAL_W-1:0] + 1'b1)
                          : $signed(q_reg[jpe_pkg::VAL_W-1:0]);
            ovf = 1'b0;
        end
    end

    assign done = done_reg;

endmodule

### src/jpe_datapath.sv
module jpe_datapath (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  jpe_pkg::ctrl_cmd_t                    cmd,
    output jpe_pkg::dp_stat_t                     stat,
    input  logic                                  req_cmd,
    input  logic [jpe_pkg::IN_DEG_W-1:0]          req_degree,
    input  logic signed [jpe_pkg::POINT_W-1:0]    req_point,
    input  logic                                  cfg_we,
    input  logic [0:0]                            cfg_index,
    input  logic signed [jpe_pkg::CFG_W-1:0]      cfg_data,
    output logic signed [jpe_pkg::VAL_W-1:0]      rsp_value,
    output logic                                  rsp_overflow
);

    logic signed [jpe_pkg::CFG_W-1:0]   alpha_reg;
    logic signed [jpe_pkg::CFG_W-1:0]   beta_reg;
    logic signed [jpe_pkg::POINT_W-1:0] x_reg;
    logic                               deriv_reg;
    logic [jpe_pkg::DEG_W-1:0]          nd_reg;
    logic [jpe_pkg::DEG_W-1:0]          jd_reg;
    logic [jpe_pkg::DEG_W-1:0]          n_reg;
    logic signed [jpe_pkg::EXP_W-1:0]   a_reg;
    logic signed [jpe_pkg::EXP_W-1:0]   b_reg;
    logic signed [jpe_pkg::VAL_W-1:0]   pc_reg;
    logic signed [jpe_pkg::VAL_W-1:0]   pm_reg;
    logic signed [jpe_pkg::VAL_W-1:0]   t1_reg;
    logic signed [jpe_pkg::VAL_W-1:0]   t2_reg;
    logic signed [jpe_pkg::VAL_W-1:0]   t3_reg;
    logic signed [jpe_pkg::VAL_W-1:0]   a1_reg;
    logic signed [jpe_pkg::VAL_W-1:0]   a2_reg;
    logic signed [jpe_pkg::VAL_W-1:0]   a3_reg;
    logic signed [jpe_pkg::VAL_W-1:0]   a4_reg;
    logic signed [jpe_pkg::VAL_W-1:0]   c_reg;
    logic signed [jpe_pkg::WIDE_W-1:0]  acc_reg;
    logic                               ovf_reg;
    logic signed [jpe_pkg::VAL_W-1:0]   out_value_reg;
    logic                               out_ovf_reg;

    logic [jpe_pkg::DEG_W-1:0]          nd_in;
    logic signed [jpe_pkg::VAL_W-1:0]   a64;
    logic signed [jpe_pkg::VAL_W-1:0]   b64;
    logic signed [jpe_pkg::VAL_W-1:0]   s64;
    logic signed [jpe_pkg::VAL_W-1:0]   x64;
    logic signed [jpe_pkg::VAL_W-1:0]   nq;
    logic signed [jpe_pkg::VAL_W-1:0]   u;
    logic signed [jpe_pkg::VAL_W-1:0]   f64;
    logic signed [jpe_pkg::VAL_W-1:0]   mul_a;
    logic signed [jpe_pkg::VAL_W-1:0]   mul_b;
    logic signed [jpe_pkg::WIDE_W-1:0]  prod;
    logic                               mul_done;
    logic signed [jpe_pkg::VAL_W-1:0]   div_q;
    logic                               div_ovf;
    logic                               div_done;
    logic signed [jpe_pkg::VAL_W-1:0]   prod_lo;
    jpe_pkg::sat_t                      sat_init;
    jpe_pkg::sat_t                      sat_c;
    jpe_pkg::sat_t                      sat_fin;

    always_comb
    begin
        if (int'(req_degree) > jpe_pkg::MAX_DEGREE)
        begin
            nd_in = jpe_pkg::DEG_W'(jpe_pkg::MAX_DEGREE);
        end
        else
        begin
            nd_in = jpe_pkg::DEG_W'(req_degree);
        end
    end

    assign a64 = jpe_pkg::VAL_W'(a_reg);
    assign b64 = jpe_pkg::VAL_W'(b_reg);
    assign s64 = a64 + b64;
    assign x64 = jpe_pkg::VAL_W'(x_reg);
    assign nq  = $signed(jpe_pkg::VAL_W'(n_reg)) <<< 10;
    assign u   = (nq <<< 1) + s64;
    assign f64 = ($signed(jpe_pkg::VAL_W'(nd_reg) + 64'd1) <<< 10)
                 + jpe_pkg::VAL_W'(alpha_reg) + jpe_pkg::VAL_W'(beta_reg);

    // operand select for the shared multiplier
    always_comb
    begin
        case (cmd.op)
            jpe_pkg::OP_INIT:
            begin
                mul_a = s64 + jpe_pkg::Q10_TWO;
                mul_b = x64;
            end
            jpe_pkg::OP_M1:
            begin
                mul_a = nq + jpe_pkg::Q10_ONE + s64;
                mul_b = u;
            end
            jpe_pkg::OP_M2:
            begin
                mul_a = $signed(jpe_pkg::VAL_W'(n_reg) + 64'd1) <<< 1;
                mul_b = t1_reg;
            end
            jpe_pkg::OP_M3:
            begin
                mul_a = a64;
                mul_b = a64;
            end
            jpe_pkg::OP_M4:
            begin
                mul_a = b64;
                mul_b = b64;
            end
            jpe_pkg::OP_M5:
            begin
                mul_a = u + jpe_pkg::Q10_ONE;
                mul_b = t2_reg - t3_reg;
            end
            jpe_pkg::OP_M6:
            begin
                mul_a = u;
                mul_b = u + jpe_pkg::Q10_ONE;
            end
            jpe_pkg::OP_M7:
            begin
                mul_a = t1_reg;
                mul_b = u + jpe_pkg::Q10_TWO;
            end
            jpe_pkg::OP_M8:
            begin
                mul_a = nq + a64;
                mul_b = nq + b64;
            end
            jpe_pkg::OP_M9:
            begin
                mul_a = t1_reg <<< 1;
                mul_b = u + jpe_pkg::Q10_TWO;
            end
            jpe_pkg::OP_M10:
            begin
                mul_a = a3_reg;
                mul_b = x64;
            end
            jpe_pkg::OP_M11:
            begin
                mul_a = c_reg;
                mul_b = pc_reg;
            end
            jpe_pkg::OP_M12:
            begin
                mul_a = a4_reg;
                mul_b = pm_reg;
            end
            jpe_pkg::OP_FINAL:
            begin
                mul_a = f64;
                mul_b = pc_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    jpe_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cmd.mul_start),
        .op_a    (mul_a),
        .op_b    (mul_b),
        .done    (mul_done),
        .product (prod)
    );

    jpe_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (acc_reg),
        .den   (a1_reg <<< 10),
        .done  (div_done),
        .quo   (div_q),
        .ovf   (div_ovf)
    );

    assign prod_lo  = prod[jpe_pkg::VAL_W-1:0];
    assign sat_init = jpe_pkg::rsh_sat((jpe_pkg::WIDE_W'(a64 - b64) <<< 30) + prod, 10);
    assign sat_c    = jpe_pkg::rsh_sat((jpe_pkg::WIDE_W'(a2_reg) <<< 30) + prod, 30);
    assign sat_fin  = jpe_pkg::rsh_sat(prod, 11);

    // exponents, cleared by reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_reg <= '0;
            beta_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                jpe_pkg::REG_ALPHA: alpha_reg <= cfg_data;
                jpe_pkg::REG_BETA:  beta_reg  <= cfg_data;
                default:            alpha_reg <= alpha_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            x_reg     <= req_point;
            deriv_reg <= req_cmd;
            nd_reg    <= nd_in;
            jd_reg    <= (req_cmd && (nd_in != '0)) ? (nd_in - 1'b1) : nd_in;
            a_reg     <= jpe_pkg::EXP_W'(alpha_reg) + (req_cmd ? jpe_pkg::EXP_SHIFT : '0);
            b_reg     <= jpe_pkg::EXP_W'(beta_reg) + (req_cmd ? jpe_pkg::EXP_SHIFT : '0);
            ovf_reg   <= 1'b0;
        end
        if (cmd.set_zero)
        begin
            pc_reg <= '0;
        end
        if (cmd.set_one)
        begin
            pc_reg <= jpe_pkg::ONE_Q31;
        end
        if (mul_done)
        begin
            case (cmd.op)
                jpe_pkg::OP_INIT:
                begin
                    pc_reg  <= sat_init.value;
                    pm_reg  <= jpe_pkg::ONE_Q31;
                    n_reg   <= jpe_pkg::DEG_W'(1);
                    ovf_reg <= ovf_reg | sat_init.ovf;
                end
                jpe_pkg::OP_M1:  t1_reg <= prod_lo;
                jpe_pkg::OP_M2:  a1_reg <= prod_lo;
                jpe_pkg::OP_M3:  t2_reg <= prod_lo;
                jpe_pkg::OP_M4:  t3_reg <= prod_lo;
                jpe_pkg::OP_M5:  a2_reg <= prod_lo;
                jpe_pkg::OP_M6:  t1_reg <= prod_lo;
                jpe_pkg::OP_M7:  a3_reg <= prod_lo;
                jpe_pkg::OP_M8:  t1_reg <= prod_lo;
                jpe_pkg::OP_M9:  a4_reg <= prod_lo;
                jpe_pkg::OP_M10:
                begin
                    c_reg   <= sat_c.value;
                    ovf_reg <= ovf_reg | sat_c.ovf;
                end
                jpe_pkg::OP_M11: acc_reg <= prod;
                jpe_pkg::OP_M12: acc_reg <= acc_reg - prod;
                jpe_pkg::OP_FINAL:
                begin
                    pc_reg  <= sat_fin.value;
                    ovf_reg <= ovf_reg | sat_fin.ovf;
                end
                default: acc_reg <= acc_reg;
            endcase
        end
        if (div_done)
        begin
            pm_reg  <= pc_reg;
            pc_reg  <= div_q;
            n_reg   <= n_reg + 1'b1;
            ovf_reg <= ovf_reg | div_ovf;
        end
        if (cmd.out_load)
        begin
            out_value_reg <= pc_reg;
            out_ovf_reg   <= ovf_reg;
        end
    end

    assign stat.deriv    = deriv_reg;
    assign stat.deg_zero = (nd_reg == '0);
    assign stat.jd_zero  = (jd_reg == '0);
    assign stat.n_done   = (n_reg >= jd_reg);
    assign stat.mul_done = mul_done;
    assign stat.div_done = div_done;

    assign rsp_value    = out_value_reg;
    assign rsp_overflow = out_ovf_reg;

endmodule

### src/jpe_ctrl.sv
`include "jacobi_polynomial_eval_assert.svh"

module jpe_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  jpe_pkg::dp_stat_t   stat,
    output jpe_pkg::ctrl_cmd_t  cmd
);

    typedef enum logic [7:0] {
        S_IDLE     = 8'b0000_0001,
        S_LOAD     = 8'b0000_0010,
        S_MUL_GO   = 8'b0000_0100,
        S_MUL_WAIT = 8'b0000_1000,
        S_DIV_GO   = 8'b0001_0000,
        S_DIV_WAIT = 8'b0010_0000,
        S_CHECK    = 8'b0100_0000,
        S_OUT      = 8'b1000_0000
    } ctrl_state_t;

    ctrl_state_t  state_reg;
    ctrl_state_t  state_next;
    jpe_pkg::op_t op_reg;
    jpe_pkg::op_t op_next;
    logic         out_valid_reg;
    logic         out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        cmd.op         = op_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                if (stat.deriv && stat.deg_zero)
                begin
                    cmd.set_zero = 1'b1;
                    state_next   = S_OUT;
                end
                else if (stat.jd_zero)
                begin
                    cmd.set_one = 1'b1;
                    if (stat.deriv)
                    begin
                        op_next    = jpe_pkg::OP_FINAL;
                        state_next = S_MUL_GO;
                    end
                    else
                    begin
                        state_next = S_OUT;
                    end
                end
                else
                begin
                    op_next    = jpe_pkg::OP_INIT;
                    state_next = S_MUL_GO;
                end
            end
            S_MUL_GO:
            begin
                cmd.mul_start = 1'b1;
                state_next    = S_MUL_WAIT;
            end
            S_MUL_WAIT:
            begin
                if (stat.mul_done)
                begin
                    case (op_reg)
                        jpe_pkg::OP_INIT:  state_next = S_CHECK;
                        jpe_pkg::OP_M12:   state_next = S_DIV_GO;
                        jpe_pkg::OP_FINAL: state_next = S_OUT;
                        default:
                        begin
                            op_next    = jpe_pkg::op_t'(op_reg + 1'b1);
                            state_next = S_MUL_GO;
                        end
                    endcase
                end
            end
            S_DIV_GO:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_DIV_WAIT;
            end
            S_DIV_WAIT:
            begin
                if (stat.div_done)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (!stat.n_done)
                begin
                    op_next    = jpe_pkg::OP_M1;
                    state_next = S_MUL_GO;
                end
                else if (stat.deriv)
                begin
                    op_next    = jpe_pkg::OP_FINAL;
                    state_next = S_MUL_GO;
                end
                else
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            op_reg        <= jpe_pkg::OP_INIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    `JPE_ASSERT_NOW(a_mul_done_waiting, clk, rst_n, stat.mul_done, state_reg == S_MUL_WAIT)
    `JPE_ASSERT_NOW(a_div_done_waiting, clk, rst_n, stat.div_done, state_reg == S_DIV_WAIT)
    `JPE_ASSERT_NEXT(a_accept_loads, clk, rst_n, in_valid && in_ready, state_reg == S_LOAD)

endmodule

### src/jacobi_polynomial_eval.sv
// channel | dir | handshake     | payload
// req     | in  | valid / ready | cmd, degree, point (Q1.30)
// rsp     | out | valid / ready | value (Q32.31, saturated), overflow
// cfg     | in  | valid / ready | index (0 alpha, 1 beta), data (Q6.10)
//
// one item at a time; each product runs on the radix-16 shared
// multiplier and each quotient on the bit-serial divider; a recurrence
// step takes its products and then one quotient, and a derivative
// request adds one final product for the derivative scaling
// rst_n is asynchronous, active low; the exponents reset to zero
// a finished result waits in the output register while the next
// transaction is accepted; the block stalls only at the hand-off
module jacobi_polynomial_eval (
    input  logic        clk,
    input  logic        rst_n,
    jpe_req_if.sink     req,
    jpe_rsp_if.source   rsp,
    jpe_cfg_if.sink     cfg
);

    jpe_pkg::ctrl_cmd_t ctrl_cmd;
    jpe_pkg::dp_stat_t  dp_stat;

    // exponent writes are always taken
    assign cfg.ready = 1'b1;

    // sequencer: walks the coefficient products, the division and the hand-off
    jpe_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .stat      (dp_stat),
        .cmd       (ctrl_cmd)
    );

    // datapath: operand registers, shared multiplier, divider, result register
    jpe_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (ctrl_cmd),
        .stat         (dp_stat),
        .req_cmd      (req.cmd),
        .req_degree   (req.degree),
        .req_point    (req.point),
        .cfg_we       (cfg.valid),
        .cfg_index    (cfg.index),
        .cfg_data     (cfg.data),
        .rsp_value    (rsp.value),
        .rsp_overflow (rsp.overflow)
    );

endmodule
